FILE: src/hsv_cv_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Word types, sextant codes, fixed-point constants and the divide-by-255
// helper shared by the converter pipeline.
// ----------------------------------------------------------------------------
package hsv_cv_pkg;

	// Input word: hue in degrees, saturation and value in percent
	typedef struct packed {
		logic [15:0] hue;
		logic [6:0]  saturation;
		logic [6:0]  brightness_value;
	} hsv_word_t;

	// Output word: 8-bit colour channels
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_word_t;

	// Hue sextant, named after the colour at its start
	typedef enum logic [2:0] {
		SEXT_RED     = 3'd0,
		SEXT_YELLOW  = 3'd1,
		SEXT_GREEN   = 3'd2,
		SEXT_CYAN    = 3'd3,
		SEXT_BLUE    = 3'd4,
		SEXT_MAGENTA = 3'd5
	} sextant_t;

	localparam logic [8:0]  HUE_FULL    = 9'd360;
	localparam logic [8:0]  HUE_SEXTANT = 9'd60;
	localparam logic [7:0]  CHAN_MAX    = 8'd255;
	localparam logic [6:0]  PCT_MAX     = 7'd100;

	// floor(h / 360) = (h * HUE_RECIP) >> 24, exact for any 16-bit h
	localparam logic [15:0] HUE_RECIP   = 16'd46604;
	// floor(c * 255 / 100) = (c * PCT_RECIP) >> 19, exact for c up to 100
	localparam logic [20:0] PCT_RECIP   = 21'd1336965;

	// Front half of the pipeline hands this to the term stages
	typedef struct packed {
		sextant_t    region;
		logic [7:0]  frac;
		logic [7:0]  sat;
		logic [7:0]  val;
		logic [15:0] p_prod;
	} hsv_cv_mid_t;

	// Truncating division by 255, exact for x up to 65279
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [15:0] sum;
		sum = x + 16'd1 + {8'd0, x[15:8]};
		return sum[15:8];
	endfunction

endpackage

FILE: src/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Integer HSV to 8-bit RGB conversion in a six-stage pipeline.
// ----------------------------------------------------------------------------
// The core takes one HSV word per clock while hsv_stall is low and returns
// the matching RGB word. The first five register stages hold the multiplies
// (hue and percent reciprocals, hue wrap, p product, saturation terms, value
// scaling), each with at most a short add after it, and the last stage is
// the output register. A stall on the rgb side holds the full stages in place
// while empty stages still fill; hsv_stall rises only when every stage is full
// and the output word is not taken. Hue may take any 16-bit value and is
// reduced modulo 360; saturation and value above 100 are treated as 100.
module hsv_to_rgb_converter_core
	import hsv_cv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      hsv_valid,
	output logic      hsv_stall,
	input  hsv_word_t hsv,
	output logic      rgb_valid,
	input  logic      rgb_stall,
	output rgb_word_t rgb
);

	logic        mid_valid;
	logic        mid_stall;
	hsv_cv_mid_t mid_word;

	// Hue reduction, scaling and sextant selection
	hsv_cv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsv_valid),
		.in_stall  (hsv_stall),
		.in_word   (hsv),
		.out_valid (mid_valid),
		.out_stall (mid_stall),
		.out_word  (mid_word)
	);

	// Term formation and channel routing
	hsv_cv_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_stall  (mid_stall),
		.in_word   (mid_word),
		.out_valid (rgb_valid),
		.out_stall (rgb_stall),
		.out_word  (rgb)
	);

endmodule

FILE: src/hsv_cv_front.sv
// ----------------------------------------------------------------------------
// HSV converter front stages
// Reduces the hue modulo 360, scales saturation and value to 0..255, picks
// the sextant and in-sextant fraction, and forms the p product.
// ----------------------------------------------------------------------------
module hsv_cv_front
	import hsv_cv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  hsv_word_t   in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output hsv_cv_mid_t out_word
);

	logic        adv_1, adv_2, adv_3;
	logic        valid_s1, valid_s2, valid_s3;

	logic [15:0] hue_s1;
	logic [7:0]  hquo_s1;
	logic [7:0]  sat_s1, val_s1;

	logic [8:0]  hmod_s2;
	logic [7:0]  sat_s2, val_s2;

	hsv_cv_mid_t mid_s3;

	logic [6:0]  sat_clamp, val_clamp;
	logic [31:0] hue_prod;
	logic [26:0] sat_prod, val_prod;
	logic [15:0] hue_wrap;
	logic [8:0]  hue_base, hue_rem;
	sextant_t    region;
	logic [9:0]  rem_x17;

	// Advance a stage when it is empty or its word moves on
	always_comb begin
		adv_3    = !valid_s3 || !out_stall;
		adv_2    = !valid_s2 || adv_3;
		adv_1    = !valid_s1 || adv_2;
		in_stall = !adv_1;
	end

	// Stage 1: clamp percentages, reciprocal multiplies
	always_comb begin
		sat_clamp = (in_word.saturation > PCT_MAX) ? PCT_MAX : in_word.saturation;
		val_clamp = (in_word.brightness_value > PCT_MAX) ? PCT_MAX
			: in_word.brightness_value;
		hue_prod  = 32'(in_word.hue) * 32'(HUE_RECIP);
		sat_prod  = 27'(sat_clamp) * 27'(PCT_RECIP);
		val_prod  = 27'(val_clamp) * 27'(PCT_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_1 && in_valid) begin
			hue_s1  <= in_word.hue;
			hquo_s1 <= hue_prod[31:24];
			sat_s1  <= sat_prod[26:19];
			val_s1  <= val_prod[26:19];
		end
	end

	// Stage 2: remove whole turns from the hue
	always_comb begin
		hue_wrap = 16'(hquo_s1) * 16'(HUE_FULL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_2 && valid_s1) begin
			hmod_s2 <= 9'(hue_s1 - hue_wrap);
			sat_s2  <= sat_s1;
			val_s2  <= val_s1;
		end
	end

	// Stage 3: sextant by comparison, fraction as rem * 17 / 4, p product
	always_comb begin
		if (hmod_s2 >= 5 * HUE_SEXTANT) begin
			region   = SEXT_MAGENTA;
			hue_base = 9'(5 * HUE_SEXTANT);
		end else if (hmod_s2 >= 4 * HUE_SEXTANT) begin
			region   = SEXT_BLUE;
			hue_base = 9'(4 * HUE_SEXTANT);
		end else if (hmod_s2 >= 3 * HUE_SEXTANT) begin
			region   = SEXT_CYAN;
			hue_base = 9'(3 * HUE_SEXTANT);
		end else if (hmod_s2 >= 2 * HUE_SEXTANT) begin
			region   = SEXT_GREEN;
			hue_base = 9'(2 * HUE_SEXTANT);
		end else if (hmod_s2 >= HUE_SEXTANT) begin
			region   = SEXT_YELLOW;
			hue_base = HUE_SEXTANT;
		end else begin
			region   = SEXT_RED;
			hue_base = 9'd0;
		end
		hue_rem = hmod_s2 - hue_base;
		rem_x17 = {hue_rem[5:0], 4'd0} + {4'd0, hue_rem[5:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_3 && valid_s2) begin
			mid_s3.region <= region;
			mid_s3.frac   <= rem_x17[9:2];
			mid_s3.sat    <= sat_s2;
			mid_s3.val    <= val_s2;
			mid_s3.p_prod <= 16'(val_s2) * 16'(CHAN_MAX - sat_s2);
		end
	end

	assign out_valid = valid_s3;
	assign out_word  = mid_s3;

endmodule

FILE: src/hsv_cv_terms.sv
// ----------------------------------------------------------------------------
// HSV converter term stages
// Forms the p, q and t terms with truncating division by 255 and routes
// them to the colour channels by sextant. The last stage is the output
// register.
// ----------------------------------------------------------------------------
module hsv_cv_terms
	import hsv_cv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  hsv_cv_mid_t in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output rgb_word_t   out_word
);

	logic        adv_4, adv_5, adv_6;
	logic        valid_s4, valid_s5, valid_s6;

	sextant_t    region_s4, region_s5;
	logic [7:0]  val_s4, val_s5;
	logic [7:0]  p_s4, p_s5;
	logic [15:0] sf_s4, sg_s4;
	logic [15:0] qm_s5, tm_s5;

	rgb_word_t   rgb_s6;
	rgb_word_t   rgb_next;
	logic [7:0]  q_term, t_term;

	// Advance a stage when it is empty or its word moves on
	always_comb begin
		adv_6    = !valid_s6 || !out_stall;
		adv_5    = !valid_s5 || adv_6;
		adv_4    = !valid_s4 || adv_5;
		in_stall = !adv_4;
	end

	// Stage 4: saturation times fraction and its complement, finish p
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv_4) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_4 && in_valid) begin
			region_s4 <= in_word.region;
			val_s4    <= in_word.val;
			p_s4      <= div255(in_word.p_prod);
			sf_s4     <= 16'(in_word.sat) * 16'(in_word.frac);
			sg_s4     <= 16'(in_word.sat) * 16'(CHAN_MAX - in_word.frac);
		end
	end

	// Stage 5: scale the q and t attenuations by value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv_5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_5 && valid_s4) begin
			region_s5 <= region_s4;
			val_s5    <= val_s4;
			p_s5      <= p_s4;
			qm_s5     <= 16'(val_s4) * 16'(CHAN_MAX - div255(sf_s4));
			tm_s5     <= 16'(val_s4) * 16'(CHAN_MAX - div255(sg_s4));
		end
	end

	// Stage 6: finish q and t, route by sextant. A zero saturation makes
	// p, q and t all equal the value, so grey needs no special path.
	always_comb begin
		q_term = div255(qm_s5);
		t_term = div255(tm_s5);
		unique case (region_s5)
			SEXT_RED:    rgb_next = '{red: val_s5, green: t_term, blue: p_s5};
			SEXT_YELLOW: rgb_next = '{red: q_term, green: val_s5, blue: p_s5};
			SEXT_GREEN:  rgb_next = '{red: p_s5,   green: val_s5, blue: t_term};
			SEXT_CYAN:   rgb_next = '{red: p_s5,   green: q_term, blue: val_s5};
			SEXT_BLUE:   rgb_next = '{red: t_term, green: p_s5,   blue: val_s5};
			default:     rgb_next = '{red: val_s5, green: p_s5,   blue: q_term};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv_6) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_6 && valid_s5) begin
			rgb_s6 <= rgb_next;
		end
	end

	assign out_valid = valid_s6;
	assign out_word  = rgb_s6;

endmodule

FILE: src/hsv_cv_checker.sv
// ----------------------------------------------------------------------------
// HSV converter port checker
// Watches the converter ports: output word hold under stall, and the count
// of words in flight against the pipeline depth.
// ----------------------------------------------------------------------------
module hsv_cv_checker
	import hsv_cv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      hsv_valid,
	input  logic      hsv_stall,
	input  logic      rgb_valid,
	input  logic      rgb_stall,
	input  rgb_word_t rgb
);

	localparam logic [3:0] DEPTH = 4'd6;

	logic       hsv_take, rgb_take;
	logic [3:0] occ_q;

	assign hsv_take = hsv_valid && !hsv_stall;
	assign rgb_take = rgb_valid && !rgb_stall;

	// Track words taken in and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 4'd0;
		end else if (hsv_take && !rgb_take) begin
			occ_q <= occ_q + 4'd1;
		end else if (rgb_take && !hsv_take) begin
			occ_q <= occ_q - 4'd1;
		end
	end

	// Hold a stalled output word
	a_rgb_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
		else $error("rgb word changed while stalled");

	// Never exceed the pipeline depth
	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH)
		else $error("more words in flight than pipeline stages");

	// Make no word out of thin air: output only for a word taken in
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> occ_q != 4'd0)
		else $error("rgb word with nothing in flight");

	// An empty pipeline never stalls its input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == 4'd0 |-> !hsv_stall)
		else $error("input stalled while pipeline empty");

	// A full pipeline with a blocked output stalls its input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == DEPTH && rgb_stall |-> hsv_stall)
		else $error("input taken while pipeline full and blocked");

endmodule

bind hsv_to_rgb_converter_core hsv_cv_checker u_hsv_cv_checker (.*);

FILE: verif/tb_hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter core testbench
// Feeds directed and random HSV words through the core and checks every RGB
// word against an integer HSV conversion worked out here, in order, with
// bursty input traffic, output stalls and a full drain part-way through.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_core
	import hsv_cv_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 850;
	localparam int TAIL_CYCLES  = 24;
	localparam int MAX_REPORTS  = 200;

	typedef struct {
		bit        drain_first;
		hsv_word_t word;
	} hsv_stim_t;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_BLOCKS
	} stall_mode_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      hsv_valid = 1'b0;
	logic      hsv_stall;
	hsv_word_t hsv       = '0;
	logic      rgb_valid;
	logic      rgb_stall = 1'b0;
	rgb_word_t rgb;

	hsv_stim_t   hsv_pending_q[$];
	rgb_word_t   rgb_due_q[$];
	bit          hsv_taken     = 1'b0;
	int          burst_left    = 8;
	int          gap_left      = 0;
	stall_mode_t stall_mode    = STALL_NONE;
	int          stall_span    = 0;
	int          error_count   = 0;
	int          hsv_words_in  = 0;
	int          rgb_words_out = 0;
	int          grey_words    = 0;
	int          clamped_words = 0;
	int          wrapped_words = 0;

	hsv_to_rgb_converter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

	always #5 clk = ~clk;

	// Integer HSV conversion: clamp and scale to 0..255, then pick the sextant
	function automatic rgb_word_t rgb_of_hsv(input hsv_word_t w);
		int unsigned s_pct, v_pct, sat8, val8, hue_deg, frac, p, q, t, r, g, b;
		sextant_t    region;
		rgb_word_t   c;
		s_pct = (w.saturation > PCT_MAX) ? PCT_MAX : w.saturation;
		v_pct = (w.brightness_value > PCT_MAX) ? PCT_MAX : w.brightness_value;
		sat8  = s_pct * CHAN_MAX / PCT_MAX;
		val8  = v_pct * CHAN_MAX / PCT_MAX;
		if (sat8 == 0) begin
			r = val8;
			g = val8;
			b = val8;
		end else begin
			hue_deg = w.hue % HUE_FULL;
			region  = sextant_t'(hue_deg / HUE_SEXTANT);
			frac    = (hue_deg % HUE_SEXTANT) * CHAN_MAX / HUE_SEXTANT;
			p = val8 * (CHAN_MAX - sat8) / CHAN_MAX;
			q = val8 * (CHAN_MAX - sat8 * frac / CHAN_MAX) / CHAN_MAX;
			t = val8 * (CHAN_MAX - sat8 * (CHAN_MAX - frac) / CHAN_MAX) / CHAN_MAX;
			case (region)
				SEXT_RED: begin
					r = val8; g = t; b = p;
				end
				SEXT_YELLOW: begin
					r = q; g = val8; b = p;
				end
				SEXT_GREEN: begin
					r = p; g = val8; b = t;
				end
				SEXT_CYAN: begin
					r = p; g = q; b = val8;
				end
				SEXT_BLUE: begin
					r = t; g = p; b = val8;
				end
				default: begin
					// magenta sextant
					r = val8; g = p; b = q;
				end
			endcase
		end
		c.red   = r[7:0];
		c.green = g[7:0];
		c.blue  = b[7:0];
		return c;
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic add_hsv(input int unsigned hue_deg, input int unsigned sat_pct,
			input int unsigned val_pct, input bit drain_first);
		hsv_stim_t s;
		s.drain_first             = drain_first;
		s.word.hue                = hue_deg[15:0];
		s.word.saturation         = sat_pct[6:0];
		s.word.brightness_value   = val_pct[6:0];
		hsv_pending_q.push_back(s);
	endtask

	// Sample both channels: check the rgb word taken, then queue the prediction
	// for the hsv word taken at this edge
	always @(posedge clk) begin : watch_words
		rgb_word_t want;
		hsv_taken = arst_n && hsv_valid && !hsv_stall;
		if (arst_n && rgb_valid && !rgb_stall) begin
			if (rgb_due_q.size() == 0) begin
				report_error($sformatf("rgb word %0d arrived with none outstanding",
					rgb_words_out));
			end else begin
				want = rgb_due_q.pop_front();
				if (rgb.red !== want.red)
					report_error($sformatf("rgb word %0d red %0d, want %0d",
						rgb_words_out, rgb.red, want.red));
				if (rgb.green !== want.green)
					report_error($sformatf("rgb word %0d green %0d, want %0d",
						rgb_words_out, rgb.green, want.green));
				if (rgb.blue !== want.blue)
					report_error($sformatf("rgb word %0d blue %0d, want %0d",
						rgb_words_out, rgb.blue, want.blue));
			end
			rgb_words_out++;
		end
		if (hsv_taken) begin
			rgb_due_q.push_back(rgb_of_hsv(hsv));
			hsv_words_in++;
			if (hsv.saturation == 0)
				grey_words++;
			if (hsv.saturation > PCT_MAX || hsv.brightness_value > PCT_MAX)
				clamped_words++;
			if (hsv.hue >= HUE_FULL)
				wrapped_words++;
		end
	end

	// Drive hsv words in bursts with gaps; hold a word until it is taken
	always @(negedge clk) begin : drive_hsv
		logic      next_valid;
		hsv_word_t next_word;
		next_valid = hsv_valid;
		next_word  = hsv;
		if (arst_n) begin
			if (hsv_valid && hsv_taken) begin
				next_valid = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (hsv_pending_q.size() > 0 &&
						!(hsv_pending_q[0].drain_first && rgb_due_q.size() > 0)) begin
					next_valid = 1'b1;
					next_word  = hsv_pending_q[0].word;
					void'(hsv_pending_q.pop_front());
				end
			end
		end
		hsv_valid <= next_valid;
		hsv       <= next_word;
	end

	// Stall the rgb side in spans, each with a pattern of its own
	always @(negedge clk) begin : stall_rgb
		logic next_stall;
		if (stall_span == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_span = $urandom_range(16, 160);
		end else begin
			stall_span--;
		end
		case (stall_mode)
			STALL_RANDOM:   next_stall = ($urandom_range(0, 9) < 3);
			STALL_PERIODIC: next_stall = (stall_span % 4 == 0);
			STALL_BLOCKS:   next_stall = ((stall_span / 12) % 2 == 1);
			default:        next_stall = 1'b0;
		endcase
		rgb_stall <= next_stall;
	end

	// Build the stimulus, release reset, then wait for the last word to drain
	initial begin : run_test
		int          i;
		int unsigned hue_deg, sat_pct, val_pct;

		// pure hues, one per sextant, and the sextant edges
		add_hsv(0, 100, 100, 1'b0);
		add_hsv(60, 100, 100, 1'b0);
		add_hsv(120, 100, 100, 1'b0);
		add_hsv(180, 100, 100, 1'b0);
		add_hsv(240, 100, 100, 1'b0);
		add_hsv(300, 100, 100, 1'b0);
		add_hsv(1, 100, 100, 1'b0);
		add_hsv(59, 100, 100, 1'b0);
		add_hsv(359, 100, 100, 1'b0);
		// hue at and beyond a full turn
		add_hsv(360, 100, 100, 1'b0);
		add_hsv(719, 80, 90, 1'b0);
		add_hsv(65535, 100, 100, 1'b0);
		add_hsv(65535, 127, 127, 1'b0);
		// zero saturation gives grey whatever the hue
		add_hsv(30, 0, 100, 1'b0);
		add_hsv(200, 0, 0, 1'b0);
		add_hsv(65535, 0, 127, 1'b0);
		add_hsv(0, 0, 0, 1'b0);
		// percent above 100 treated as 100
		add_hsv(90, 127, 127, 1'b0);
		add_hsv(150, 101, 101, 1'b0);
		add_hsv(270, 127, 50, 1'b0);
		// small and mid values
		add_hsv(330, 1, 1, 1'b0);
		add_hsv(210, 100, 0, 1'b0);
		add_hsv(45, 50, 50, 1'b0);
		add_hsv(0, 0, 0, 1'b0);

		for (i = 0; i < RANDOM_WORDS; i++) begin
			case ($urandom_range(0, 9))
				0, 1: hue_deg = $urandom_range(0, 65535);
				2: begin
					hue_deg = $urandom_range(0, 5) * 60;
					case ($urandom_range(0, 2))
						0: hue_deg = hue_deg + 1;
						1: hue_deg = hue_deg + 59;
						default: ;
					endcase
				end
				default: hue_deg = $urandom_range(0, 359);
			endcase
			case ($urandom_range(0, 9))
				0: sat_pct = 0;
				1: sat_pct = $urandom_range(101, 127);
				2: sat_pct = 100;
				default: sat_pct = $urandom_range(0, 100);
			endcase
			case ($urandom_range(0, 9))
				0: val_pct = 0;
				1: val_pct = $urandom_range(101, 127);
				2: val_pct = 100;
				default: val_pct = $urandom_range(0, 100);
			endcase
			add_hsv(hue_deg, sat_pct, val_pct,
				i == 0 || i == RANDOM_WORDS / 2 || $urandom_range(0, 199) == 0);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (hsv_pending_q.size() != 0 || hsv_valid)
			@(negedge clk);
		while (rgb_due_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d hsv words (%0d grey, %0d clamped, %0d hue wrapped)",
			hsv_words_in, grey_words, clamped_words, wrapped_words);
		$display("checked %0d rgb words under bursty input and output stalls, %0d errors",
			rgb_words_out, error_count);
		if (error_count == 0) begin
			$display("tb_hsv_to_rgb_converter_core: done, clean");
		end else begin
			$display("tb_hsv_to_rgb_converter_core: done, errors");
		end
		$finish;
	end

	// Give up well past the slowest correct run
	initial begin : watchdog
		#2000000;
		$display("timeout with %0d rgb words outstanding", rgb_due_q.size());
		$display("tb_hsv_to_rgb_converter_core: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
src/hsv_cv_pkg.sv
src/hsv_cv_front.sv
src/hsv_cv_terms.sv
src/hsv_to_rgb_converter_core.sv
src/hsv_cv_checker.sv
verif/tb_hsv_to_rgb_converter_core.sv
